FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RWMV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwmv check failed");

// Next-cycle implication, disabled during reset.
`define RWMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwmv check failed");

// Condition that must hold in the cycle after a reset edge.
`define RWMV_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("rwmv check failed");

`endif

FILE: hdl/rwmv_pkg.sv
// Shared constants, types and helpers of the rolling window mean and variance block.
package rwmv_pkg;

    localparam int MAX_WINDOW    = 1024;
    localparam int IDX_W         = $clog2(MAX_WINDOW);
    localparam int WIN_W         = $clog2(MAX_WINDOW + 1);
    localparam int CFG_WIN_W     = 11;
    localparam int SAMPLE_W      = 24;
    localparam int DEV_W         = SAMPLE_W + 1;
    localparam int SQ_W          = 2 * SAMPLE_W;
    localparam int DSUM_W        = SAMPLE_W + WIN_W + 1;
    localparam int SSUM_W        = SQ_W + WIN_W + 1;
    localparam int MEAN_W        = 32;
    localparam int VAR_W         = 56;
    localparam int MSUM_W        = DSUM_W + 10;
    localparam int REBASE_FACTOR = 25;
    localparam int K_W           = 2 * WIN_W + 5;

    localparam int MUL_A_W     = 72;
    localparam int MUL_B_W     = 36;
    localparam int MUL_DIGIT   = 4;
    localparam int MUL_STEPS   = MUL_B_W / MUL_DIGIT;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

    localparam int DIV_N_W     = 80;
    localparam int DIV_D_W     = 2 * WIN_W;
    localparam int DIV_CNT_W   = $clog2(DIV_N_W);

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = '0;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SP_A,
        S_SP_AW,
        S_SP_B,
        S_SP_BW,
        S_D,
        S_DSQ,
        S_OD,
        S_ODSQ,
        S_ODSUB,
        S_ADV,
        S_RB_M,
        S_RB_MW,
        S_RB_L,
        S_RB_LW,
        S_RB_R,
        S_RB_RW,
        S_RB_DIV,
        S_RB_DIVW,
        S_WALK,
        S_MEAN,
        S_MEANW,
        S_VDIV,
        S_VDIVW,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                       we;
        logic [IDX_W-1:0]           waddr;
        logic signed [SAMPLE_W-1:0] wdata;
        logic [IDX_W-1:0]           raddr;
    } t_ring_req;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [CFG_WIN_W-1:0] v);
        logic [WIN_W-1:0] res;
        if (v < CFG_WIN_W'(2)) begin
            res = WIN_W'(2);
        end else if (32'(v) > MAX_WINDOW) begin
            res = WIN_W'(MAX_WINDOW);
        end else begin
            res = WIN_W'(v);
        end
        return res;
    endfunction

endpackage

FILE: hdl/rolling_window_mean_variance.sv
// Top level: sliding-window mean and variance over a ring of samples.
// Input channel i_valid/o_stall carries one signed 24-bit sample per transfer.
// Output channel o_valid/i_stall carries mean (Q8), variance (Q8), variance_valid
// and rebased for each sample, one result per input.
// The configuration port (APB style, pready always high) holds window_length at
// address 0; writing it clears the ring position, count, reference and sums.
// One sample at a time: o_stall is high from acceptance until its result is
// loaded into the output register. Each item runs through the 80-step divider
// (one division, two once two samples are in the window) and the 9-step
// multiplier (up to seven products). A re-centring adds one more division and
// a walk through the ring memory, one sample per cycle.
// The result waits in its own register; the next sample is accepted meanwhile,
// and only the loading of the following result waits while i_stall is high.
// Reset: window length 1024, empty window, no result pending.
module rolling_window_mean_variance (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [rwmv_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [rwmv_pkg::MEAN_W-1:0]      o_mean_q8,
    output logic [rwmv_pkg::VAR_W-1:0]              o_variance_q8,
    output logic                                    o_variance_valid,
    output logic                                    o_rebased,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rwmv_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [rwmv_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [rwmv_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import rwmv_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0]           r_wslot;
    logic [WIN_W-1:0]           r_fill;
    logic [WIN_W-1:0]           r_np;
    logic [WIN_W-1:0]           r_wlen;
    logic [WIN_W-1:0]           r_walk;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_ref;
    logic signed [DSUM_W-1:0]   r_dsum;
    logic [SSUM_W-1:0]          r_ssum;
    logic signed [DEV_W-1:0]    r_e;
    logic [SQ_W-1:0]            r_sq;
    logic [MUL_A_W-1:0]         r_pa;
    logic [MUL_A_W-1:0]         r_spread;
    logic [MUL_P_W-1:0]         r_pb;
    logic [2*WIN_W-1:0]         r_nn;
    logic [DIV_D_W-1:0]         r_npp;
    logic [K_W-1:0]             r_k;
    logic                       r_in_var;
    logic                       r_rebased;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic signed [MEAN_W-1:0]   r_mean;
    logic [VAR_W-1:0]           r_var;
    logic                       r_ovalid;
    logic signed [MEAN_W-1:0]   r_o_mean;
    logic [VAR_W-1:0]           r_o_var;
    logic                       r_o_vvalid;
    logic                       r_o_rebased;

    logic                       w_in_acc;
    logic                       w_cfg_wr;
    logic                       w_cfg_sel;
    logic                       w_out_load;
    logic                       w_issue;
    logic                       w_neg;
    logic [DSUM_W-1:0]          w_m;
    logic [WIN_W-1:0]           w_nsel;
    logic [WIN_W-1:0]           w_slot_inc;
    logic signed [2*DEV_W-1:0]  w_prod;
    logic [SQ_W-1:0]            w_esq;
    logic signed [SAMPLE_W-1:0] w_qref;
    logic signed [MSUM_W-1:0]   w_ref_q8;
    logic signed [MSUM_W-1:0]   w_qm;
    logic signed [MSUM_W-1:0]   w_msum;
    logic                       w_mean_ovf;
    logic signed [MEAN_W-1:0]   w_mean_sat;
    logic [VAR_W-1:0]           w_var_sat;

    logic                       mul_start;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic                       mul_done;
    logic [MUL_P_W-1:0]         mul_p;
    logic                       div_start;
    logic [DIV_N_W-1:0]         div_num;
    logic [DIV_D_W-1:0]         div_den;
    logic                       div_done;
    logic [DIV_N_W-1:0]         div_q;
    t_ring_req                  ring_req;
    logic signed [SAMPLE_W-1:0] ring_rdata;

    rwmv_ring u_ring (
        .i_clk   (i_clk),
        .i_req   (ring_req),
        .o_rdata (ring_rdata)
    );

    rwmv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    rwmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW);
    assign prdata    = w_cfg_sel ? CFG_DATA_W'(r_wlen) : '0;
    assign pready    = 1'b1;

    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign w_issue    = (r_state == S_WALK) && (r_walk != r_fill);
    assign w_neg      = r_dsum[DSUM_W-1];
    assign w_m        = w_neg ? DSUM_W'(-r_dsum) : DSUM_W'(r_dsum);
    assign w_nsel     = r_in_var ? r_fill : r_np;
    assign w_slot_inc = WIN_W'(r_wslot) + 1'b1;
    assign w_prod     = r_e * r_e;
    assign w_esq      = w_prod[SQ_W-1:0];
    assign w_qref     = div_q[SAMPLE_W-1:0];

    assign w_ref_q8   = {{(MSUM_W-SAMPLE_W-8){r_ref[SAMPLE_W-1]}}, r_ref, 8'b0};
    assign w_qm       = {1'b0, div_q[MSUM_W-2:0]};
    assign w_msum     = w_neg ? (w_ref_q8 - w_qm) : (w_ref_q8 + w_qm);
    assign w_mean_ovf = !((&w_msum[MSUM_W-1:MEAN_W-1]) || !(|w_msum[MSUM_W-1:MEAN_W-1]));
    assign w_mean_sat = !w_mean_ovf ? w_msum[MEAN_W-1:0] :
                        (w_msum[MSUM_W-1] ? {1'b1, {(MEAN_W-1){1'b0}}}
                                          : {1'b0, {(MEAN_W-1){1'b1}}});
    assign w_var_sat  = (|div_q[DIV_N_W-1:VAR_W]) ? {VAR_W{1'b1}} : div_q[VAR_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_in_acc) n_state = (r_fill >= WIN_W'(2)) ? S_SP_A : S_D;
            S_SP_A:    n_state = S_SP_AW;
            S_SP_AW:   if (mul_done) n_state = S_SP_B;
            S_SP_B:    n_state = S_SP_BW;
            S_SP_BW:   if (mul_done) n_state = r_in_var ? S_VDIV : S_D;
            S_D:       n_state = S_DSQ;
            S_DSQ:     n_state = S_OD;
            S_OD:      n_state = (r_fill >= r_wlen) ? S_ODSQ : S_ADV;
            S_ODSQ:    n_state = S_ODSUB;
            S_ODSUB:   n_state = S_ADV;
            S_ADV:     n_state = (r_np >= WIN_W'(2)) ? S_RB_M : S_MEAN;
            S_RB_M:    n_state = S_RB_MW;
            S_RB_MW:   if (mul_done) n_state = S_RB_L;
            S_RB_L:    n_state = S_RB_LW;
            S_RB_LW:   if (mul_done) n_state = S_RB_R;
            S_RB_R:    n_state = S_RB_RW;
            S_RB_RW:   if (mul_done) n_state = (r_pb > mul_p) ? S_RB_DIV : S_MEAN;
            S_RB_DIV:  n_state = S_RB_DIVW;
            S_RB_DIVW: if (div_done) n_state = S_WALK;
            S_WALK:    if (!w_issue && !r_v1 && !r_v2 && !r_v3) n_state = S_MEAN;
            S_MEAN:    n_state = S_MEANW;
            S_MEANW:   if (div_done) n_state = (r_fill >= WIN_W'(2)) ? S_SP_A : S_OUT;
            S_VDIV:    n_state = S_VDIVW;
            S_VDIVW:   if (div_done) n_state = S_OUT;
            S_OUT:     if (w_out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        ring_req.we    = (r_state == S_ADV);
        ring_req.waddr = r_wslot;
        ring_req.wdata = r_x;
        ring_req.raddr = (r_state == S_WALK) ? r_walk[IDX_W-1:0] : r_wslot;
        unique case (r_state)
            S_SP_A: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(r_ssum);
                mul_b     = MUL_B_W'(w_nsel);
            end
            S_SP_B, S_RB_M: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(w_m);
                mul_b     = MUL_B_W'(w_m);
            end
            S_RB_L: begin
                mul_start = 1'b1;
                mul_a     = r_pa;
                mul_b     = MUL_B_W'(r_npp);
            end
            S_RB_R: begin
                mul_start = 1'b1;
                mul_a     = r_spread;
                mul_b     = MUL_B_W'(r_k);
            end
            S_RB_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_N_W'(w_m) + DIV_N_W'(r_fill >> 1);
                div_den   = DIV_D_W'(r_fill);
            end
            S_MEAN: begin
                div_start = 1'b1;
                div_num   = (DIV_N_W'(w_m) << 8) + DIV_N_W'(r_fill >> 1);
                div_den   = DIV_D_W'(r_fill);
            end
            S_VDIV: begin
                div_start = 1'b1;
                div_num   = (DIV_N_W'(r_spread) << 8) + DIV_N_W'(r_npp >> 1);
                div_den   = r_npp;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen    <= WIN_W'(MAX_WINDOW);
            r_wslot   <= '0;
            r_fill    <= '0;
            r_ref     <= '0;
            r_dsum    <= '0;
            r_ssum    <= '0;
            r_ovalid  <= 1'b0;
            r_in_var  <= 1'b0;
            r_rebased <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_walk    <= '0;
        end else begin
            if (w_cfg_wr && w_cfg_sel) begin
                r_wlen  <= clamp_window(pwdata[CFG_WIN_W-1:0]);
                r_wslot <= '0;
                r_fill  <= '0;
                r_ref   <= '0;
                r_dsum  <= '0;
                r_ssum  <= '0;
            end
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_x       <= i_sample;
                        r_np      <= r_fill;
                        r_in_var  <= 1'b0;
                        r_rebased <= 1'b0;
                        if (r_fill == '0) begin
                            r_ref <= i_sample;
                        end
                    end
                end
                S_SP_AW: begin
                    if (mul_done) r_pa <= mul_p[MUL_A_W-1:0];
                end
                S_SP_BW: begin
                    if (mul_done) begin
                        r_spread <= (MUL_P_W'(r_pa) < mul_p) ? '0 : r_pa - mul_p[MUL_A_W-1:0];
                    end
                end
                S_D: begin
                    r_e <= DEV_W'(r_x) - DEV_W'(r_ref);
                end
                S_DSQ: begin
                    r_sq   <= w_esq;
                    r_dsum <= r_dsum + DSUM_W'(r_e);
                end
                S_OD: begin
                    r_ssum <= r_ssum + SSUM_W'(r_sq);
                    r_e    <= DEV_W'(ring_rdata) - DEV_W'(r_ref);
                end
                S_ODSQ: begin
                    r_sq   <= w_esq;
                    r_dsum <= r_dsum - DSUM_W'(r_e);
                end
                S_ODSUB: begin
                    r_ssum <= r_ssum - SSUM_W'(r_sq);
                end
                S_ADV: begin
                    r_wslot <= (w_slot_inc >= r_wlen) ? '0 : w_slot_inc[IDX_W-1:0];
                    if (r_fill < r_wlen) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                S_RB_M: begin
                    r_nn  <= (2*WIN_W)'(r_fill) * (2*WIN_W)'(r_fill);
                    r_npp <= DIV_D_W'(r_np) * DIV_D_W'(r_np - 1'b1);
                end
                S_RB_MW: begin
                    r_k <= K_W'(r_nn) * K_W'(REBASE_FACTOR);
                    if (mul_done) r_pa <= mul_p[MUL_A_W-1:0];
                end
                S_RB_LW: begin
                    if (mul_done) r_pb <= mul_p;
                end
                S_RB_DIVW: begin
                    if (div_done) begin
                        r_ref     <= w_neg ? (r_ref - w_qref) : (r_ref + w_qref);
                        r_dsum    <= '0;
                        r_ssum    <= '0;
                        r_walk    <= '0;
                        r_v1      <= 1'b0;
                        r_v2      <= 1'b0;
                        r_v3      <= 1'b0;
                        r_rebased <= 1'b1;
                    end
                end
                S_WALK: begin
                    if (w_issue) r_walk <= r_walk + 1'b1;
                    r_v1 <= w_issue;
                    r_v2 <= r_v1;
                    r_v3 <= r_v2;
                    if (r_v1) r_e <= DEV_W'(ring_rdata) - DEV_W'(r_ref);
                    if (r_v2) begin
                        r_sq   <= w_esq;
                        r_dsum <= r_dsum + DSUM_W'(r_e);
                    end
                    if (r_v3) r_ssum <= r_ssum + SSUM_W'(r_sq);
                end
                S_MEANW: begin
                    if (div_done) begin
                        r_mean   <= w_mean_sat;
                        r_in_var <= 1'b1;
                        r_npp    <= DIV_D_W'(r_fill) * DIV_D_W'(r_fill - 1'b1);
                        if (r_fill < WIN_W'(2)) r_var <= '0;
                    end
                end
                S_VDIVW: begin
                    if (div_done) r_var <= w_var_sat;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_ovalid    <= 1'b1;
                        r_o_mean    <= r_mean;
                        r_o_var     <= r_var;
                        r_o_vvalid  <= (r_fill >= WIN_W'(2));
                        r_o_rebased <= r_rebased;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_mean_q8        = r_o_mean;
    assign o_variance_q8    = r_o_var;
    assign o_variance_valid = r_o_vvalid;
    assign o_rebased        = r_o_rebased;

endmodule

FILE: hdl/rwmv_ring.sv
// Sample ring memory: one write port, one registered read port.
module rwmv_ring (
    input  logic                                 i_clk,
    input  rwmv_pkg::t_ring_req                  i_req,
    output logic signed [rwmv_pkg::SAMPLE_W-1:0] o_rdata
);
    import rwmv_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/rwmv_mul.sv
// Digit-serial unsigned multiplier, four multiplier bits per cycle.
module rwmv_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rwmv_pkg::MUL_A_W-1:0] i_a,
    input  logic [rwmv_pkg::MUL_B_W-1:0] i_b,
    output logic                         o_done,
    output logic [rwmv_pkg::MUL_P_W-1:0] o_p
);
    import rwmv_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_P_W-1:0]   r_acc;
    logic [MUL_P_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_P_W-1:0]   w_part;

    assign w_part = r_a * MUL_P_W'(r_b[MUL_DIGIT-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_a    <= MUL_P_W'(i_a);
            r_b    <= i_b;
        end else if (r_busy) begin
            r_acc <= r_acc + w_part;
            r_a   <= r_a << MUL_DIGIT;
            r_b   <= r_b >> MUL_DIGIT;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

FILE: hdl/rwmv_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module rwmv_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rwmv_pkg::DIV_N_W-1:0] i_num,
    input  logic [rwmv_pkg::DIV_D_W-1:0] i_den,
    output logic                         o_done,
    output logic [rwmv_pkg::DIV_N_W-1:0] o_quot
);
    import rwmv_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_N_W-1:0]   r_q;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_D_W:0]     w_t;
    logic [DIV_D_W:0]     w_diff;
    logic                 w_ge;

    assign w_t    = {r_rem, r_q[DIV_N_W-1]};
    assign w_diff = w_t - {1'b0, r_den};
    assign w_ge   = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_D_W-1:0] : w_t[DIV_D_W-1:0];
            r_q   <= {r_q[DIV_N_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: hdl/rwmv_chk.sv
// Port-level checker for the rolling window mean and variance block, with its bind.
`include "assert_macros.svh"

module rwmv_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [rwmv_pkg::MEAN_W-1:0]   o_mean_q8,
    input logic [rwmv_pkg::VAR_W-1:0]           o_variance_q8,
    input logic                                 o_variance_valid,
    input logic                                 o_rebased,
    input logic                                 psel,
    input logic                                 pready
);

    `RWMV_ASSERT_SAME(a_pready, i_clk, i_rst_n, psel, pready)
    `RWMV_ASSERT_SAME(a_reb_var, i_clk, i_rst_n, o_valid && o_rebased, o_variance_valid)
    `RWMV_ASSERT_SAME(a_var_zero, i_clk, i_rst_n, o_valid && !o_variance_valid, o_variance_q8 == '0)
    `RWMV_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_mean_q8) && $stable(o_variance_q8))
    `RWMV_ASSERT_RST(a_rst, i_clk, i_rst_n, !o_valid && !o_stall)

endmodule

bind rolling_window_mean_variance rwmv_chk u_rwmv_chk (.*);

FILE: test/tb.sv
// Testbench for rolling_window_mean_variance: random samples checked against a window-statistics predictor.
`timescale 1ns / 1ps

module tb;
    import rwmv_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int IDLE_WAIT    = 400;
    localparam int TAIL_ITEMS   = 150;
    localparam logic [1:0] BUS_IDLE   = 2'd0;
    localparam logic [1:0] BUS_SETUP  = 2'd1;
    localparam logic [1:0] BUS_ACCESS = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = CFG_ADDR_W'({REG_WINDOW, 2'b00});
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = CFG_ADDR_W'(4);
    localparam int S_MIN = -8388608;
    localparam int S_MAX = 8388607;

    typedef struct {
        bit                      is_cfg;
        logic [CFG_ADDR_W-1:0]   addr;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [SAMPLE_W-1:0] sample;
    } t_pending;

    typedef struct {
        logic signed [MEAN_W-1:0] mean_q8;
        logic [VAR_W-1:0]         variance_q8;
        logic                     variance_valid;
        logic                     rebased;
    } t_stats;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [MEAN_W-1:0] o_mean_q8;
    logic [VAR_W-1:0] o_variance_q8;
    logic o_variance_valid;
    logic o_rebased;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    rolling_window_mean_variance DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_sample(i_sample),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_mean_q8(o_mean_q8), .o_variance_q8(o_variance_q8),
        .o_variance_valid(o_variance_valid), .o_rebased(o_rebased),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // window statistics predictor state
    logic signed [SAMPLE_W-1:0] win_ring [MAX_WINDOW];
    int unsigned win_len = MAX_WINDOW;
    int unsigned win_slot = 0;
    int unsigned win_fill = 0;
    longint      win_ref = 0;
    longint      dev_sum = 0;
    logic [63:0] sq_sum = '0;

    t_pending pending [$];
    t_stats   stats_expected [$];
    int errors = 0;
    int results_seen = 0;

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [127:0] spread(input int unsigned n);
        logic [127:0] a, b;
        logic [63:0] m;
        m = mag(dev_sum);
        a = 128'(sq_sum) * 128'(n);
        b = 128'(m) * 128'(m);
        return (a < b) ? 128'd0 : a - b;
    endfunction

    function automatic longint round_div(input longint num, input int unsigned den);
        logic [63:0] m, q;
        m = mag(num);
        q = (m + 64'(den / 2)) / 64'(den);
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic void window_apply_cfg(input logic [CFG_ADDR_W-1:0] addr,
                                             input logic [CFG_DATA_W-1:0] data);
        int unsigned v;
        if (addr[CFG_ADDR_W-1:2] != REG_WINDOW) return;
        v = data & 32'h7FF;
        win_len = (v < 2) ? 2 : ((v > MAX_WINDOW) ? MAX_WINDOW : v);
        win_slot = 0;
        win_fill = 0;
        win_ref = 0;
        dev_sum = 0;
        sq_sum = '0;
    endfunction

    function automatic t_stats window_stats_step(input logic signed [SAMPLE_W-1:0] x);
        t_stats r;
        int unsigned np, n;
        logic [127:0] prev, lhs, rhs, num, q;
        logic [63:0] m, den;
        longint d, od, e, mean;
        np = win_fill;
        prev = '0;
        r.rebased = 1'b0;
        r.variance_q8 = '0;
        if (np >= 2) prev = spread(np);
        if (np == 0) win_ref = longint'(x);
        d = longint'(x) - win_ref;
        dev_sum += d;
        sq_sum += mag(d) * mag(d);
        if (win_fill >= win_len) begin
            od = longint'(win_ring[win_slot]) - win_ref;
            dev_sum -= od;
            sq_sum -= mag(od) * mag(od);
        end
        win_ring[win_slot] = x;
        win_slot++;
        if (win_slot >= win_len) win_slot = 0;
        if (win_fill < win_len) win_fill++;
        n = win_fill;
        if (np >= 2) begin
            m = mag(dev_sum);
            lhs = 128'(m) * 128'(m) * 128'(64'(np) * 64'(np - 1));
            rhs = prev * 128'(64'(25) * 64'(n) * 64'(n));
            if (lhs > rhs) begin
                win_ref = win_ref + round_div(dev_sum, n);
                dev_sum = 0;
                sq_sum = '0;
                for (int i = 0; i < n; i++) begin
                    e = longint'(win_ring[i]) - win_ref;
                    dev_sum += e;
                    sq_sum += mag(e) * mag(e);
                end
                r.rebased = 1'b1;
            end
        end
        mean = win_ref * 256 + round_div(dev_sum * 256, n);
        if (mean > 64'sd2147483647) mean = 64'sd2147483647;
        if (mean < -64'sd2147483648) mean = -64'sd2147483648;
        r.mean_q8 = mean[31:0];
        if (n >= 2) begin
            num = spread(n) << 8;
            den = 64'(n) * 64'(n - 1);
            q = (num + 128'(den / 2)) / 128'(den);
            r.variance_q8 = (q > 128'((64'd1 << 56) - 1)) ? {VAR_W{1'b1}} : q[VAR_W-1:0];
        end
        r.variance_valid = (n >= 2);
        return r;
    endfunction

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, field, got,
                 want);
        errors++;
    endtask

    // driver
    logic [1:0] bus_phase = BUS_IDLE;
    int tx_gap = 0;
    int idle_cycles = 0;

    always @(posedge i_clk) begin : drive
        bit nv;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                stats_expected.push_back(window_stats_step(i_sample));
                void'(pending.pop_front());
                if (pending.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
                    tx_gap = $urandom_range(1, 15);
            end
            if (stats_expected.size() == 0 && !i_valid) idle_cycles++;
            else idle_cycles = 0;
            if (bus_phase == BUS_SETUP) begin
                penable <= 1'b1;
                bus_phase = BUS_ACCESS;
            end else if (bus_phase == BUS_ACCESS) begin
                window_apply_cfg(paddr, pwdata);
                psel <= 1'b0;
                penable <= 1'b0;
                pwrite <= 1'b0;
                void'(pending.pop_front());
                bus_phase = BUS_IDLE;
                idle_cycles = 0;
            end else begin
                nv = i_valid && o_stall;
                if (!nv) begin
                    if (tx_gap > 0) begin
                        tx_gap--;
                    end else if (pending.size() > 0) begin
                        if (pending[0].is_cfg) begin
                            if (idle_cycles >= IDLE_WAIT) begin
                                psel <= 1'b1;
                                pwrite <= 1'b1;
                                paddr <= pending[0].addr;
                                pwdata <= pending[0].data;
                                bus_phase = BUS_SETUP;
                            end
                        end else begin
                            nv = 1'b1;
                            i_sample <= pending[0].sample;
                        end
                    end
                end
                i_valid <= nv;
            end
        end
    end

    // receiver hold-off
    int rx_hold = 0;
    bit rx_held = 0;

    always @(posedge i_clk) begin : hold_off
        if (i_rst_n) begin
            if (rx_hold > 0) begin
                rx_hold--;
            end else if (!rx_held && results_seen >= 60) begin
                rx_held = 1;
                rx_hold = 3000;
            end
        end
    end

    // monitor
    int rx_gap = 0;

    always @(posedge i_clk) begin : monitor
        t_stats want;
        bit st;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (stats_expected.size() == 0) begin
                    report("unexpected transfer", 64'(o_mean_q8), 64'd0);
                end else begin
                    want = stats_expected.pop_front();
                    if (o_mean_q8 !== want.mean_q8)
                        report("mean_q8", 64'(o_mean_q8), 64'(want.mean_q8));
                    if (o_variance_q8 !== want.variance_q8)
                        report("variance_q8", 64'(o_variance_q8), 64'(want.variance_q8));
                    if (o_variance_valid !== want.variance_valid)
                        report("variance_valid", 64'(o_variance_valid),
                               64'(want.variance_valid));
                    if (o_rebased !== want.rebased)
                        report("rebased", 64'(o_rebased), 64'(want.rebased));
                end
                results_seen++;
            end
            if (rx_hold > 0) begin
                st = 1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                st = 1;
            end else if (pending.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(0, 14);
                st = 1;
            end else begin
                st = 0;
            end
            i_stall <= st;
        end
    end

    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int clamp_sample(input longint v);
        return (v < S_MIN) ? S_MIN : ((v > S_MAX) ? S_MAX : int'(v));
    endfunction

    task automatic add_sample(input int v);
        t_pending p;
        p.is_cfg = 0;
        p.addr = '0;
        p.data = '0;
        p.sample = SAMPLE_W'(v);
        pending.push_back(p);
    endtask

    task automatic add_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        t_pending p;
        p.is_cfg = 1;
        p.addr = addr;
        p.data = data;
        p.sample = '0;
        pending.push_back(p);
    endtask

    task automatic add_segments(input int count);
        int made, len, kind, level, spread_amt;
        made = 0;
        level = $urandom_range(0, 32'hFFFFFF) - 8388608;
        while (made < count) begin
            kind = $urandom_range(0, 4);
            len = $urandom_range(3, 25);
            spread_amt = 1 << $urandom_range(0, 20);
            if (kind == 3) level = $urandom_range(0, 32'hFFFFFF) - 8388608;
            for (int i = 0; i < len && made < count; i++) begin
                case (kind)
                    0: add_sample($urandom_range(0, 32'hFFFFFF) - 8388608);
                    1, 3: add_sample(clamp_sample(longint'(level) +
                                     $urandom_range(0, 2 * spread_amt) - spread_amt));
                    2: add_sample(level);
                    default: add_sample($urandom_range(0, 1) ? S_MAX : S_MIN);
                endcase
                made++;
            end
        end
    endtask

    initial begin
        // directed: extremes, constant run then jump, tiny window, out-of-range lengths
        add_sample(S_MAX);
        add_sample(S_MIN);
        add_sample(0);
        add_sample(-1);
        add_sample(1);
        add_sample(5);
        add_sample(5);
        add_sample(5);
        add_sample(1000);
        add_sample(1000);
        add_cfg(ADDR_WINDOW, 32'h0000_0000);
        add_sample(7);
        add_sample(7);
        add_sample(-7);
        add_sample(S_MAX);
        add_sample(S_MIN);
        add_sample(S_MAX);
        add_cfg(ADDR_UNUSED, 32'h0000_0003);
        add_sample(S_MIN);
        add_cfg(ADDR_WINDOW, 32'h0000_07FF);
        add_sample(3);
        add_sample(3);

        add_cfg(ADDR_WINDOW, 32'd2);
        add_segments(100);
        add_cfg(ADDR_WINDOW, 32'd3);
        add_segments(100);
        add_cfg(ADDR_WINDOW, 32'd300);
        add_segments(400);
        add_cfg(ADDR_WINDOW, 32'd1024);
        add_segments(150);
        add_cfg(ADDR_WINDOW, 32'hFFFF_F805);
        add_segments(100);
        for (int k = 0; k < 9; k++) begin
            add_cfg(ADDR_WINDOW, ($urandom() & 32'hFFFF_F800) | $urandom_range(4, 40));
            add_segments(120);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending.size() > 0 || stats_expected.size() > 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (errors == 0 && stats_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: rolling_window_mean_variance.f
+incdir+hdl
hdl/rwmv_pkg.sv
hdl/rwmv_ring.sv
hdl/rwmv_mul.sv
hdl/rwmv_div.sv
hdl/rolling_window_mean_variance.sv
hdl/rwmv_chk.sv
test/tb.sv
